### rtl/tagged_rational_alu_defines.svh
// Assertion macros for the rational ALU
`ifndef TAGGED_RATIONAL_ALU_DEFINES_SVH
`define TAGGED_RATIONAL_ALU_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define TRA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tra: %s failed", "label");
// next-cycle implication
`define TRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tra: %s failed", "label");
`endif

### rtl/tra_pkg.sv
// ----------------------------------------------------------------------------
// tra_pkg
// Shared constants for the rational ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tra_pkg;
  localparam int unsigned WordBitsDef = 32;
  localparam logic [2:0] ActAdd = 3'd0;
  localparam logic [2:0] ActSub = 3'd1;
  localparam logic [2:0] ActMul = 3'd2;
  localparam logic [2:0] ActDiv = 3'd3;
  localparam logic [2:0] ActGt  = 3'd4;
  localparam logic [2:0] ActLt  = 3'd5;
  localparam logic [2:0] ActEq  = 3'd6;
  localparam logic [2:0] ActUnused = 3'd7;
  localparam logic [1:0] KindInt  = 2'd0;
  localparam logic [1:0] KindFrac = 2'd1;
  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrDivZero = 2'd1;
  localparam logic [1:0] ErrReal = 2'd2;
endpackage
`default_nettype wire

### rtl/tra_divider.sv
// ----------------------------------------------------------------------------
// tra_divider
// Restoring truncating signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tra_divider import tra_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [WordBits-1:0] a_i,
  input  wire logic [WordBits-1:0] b_i,
  output logic                     done_o,
  output logic [WordBits-1:0]      q_o,
  output logic [WordBits-1:0]      r_o
);
  localparam int unsigned CntBits = $clog2(WordBits + 1);
  logic [WordBits-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d, qneg_q, qneg_d, rneg_q, rneg_d;
  logic [WordBits:0]   trial;
  logic [WordBits-1:0] ma, mb;

  assign ma = a_i[WordBits-1] ? (~a_i + 1'b1) : a_i;
  assign mb = b_i[WordBits-1] ? (~b_i + 1'b1) : b_i;
  assign trial = {rem_q, quo_q[WordBits-1]} - {1'b0, dvs_q};

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; qneg_d = qneg_q; rneg_d = rneg_q;
    // done does not look at start, so a new division may be launched on it
    done_o = busy_q && (cnt_q == '0);
    if (start_i) begin
      rem_d = '0; quo_d = ma; dvs_d = mb; busy_d = 1'b1;
      cnt_d = CntBits'(WordBits);
      qneg_d = a_i[WordBits-1] ^ b_i[WordBits-1];
      rneg_d = a_i[WordBits-1];
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (!trial[WordBits]) begin
          rem_d = trial[WordBits-1:0];
          quo_d = {quo_q[WordBits-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[WordBits-2:0], quo_q[WordBits-1]};
          quo_d = {quo_q[WordBits-2:0], 1'b0};
        end
      end
    end
  end
  assign q_o = qneg_q ? (~quo_q + 1'b1) : quo_q;
  assign r_o = rneg_q ? (~rem_q + 1'b1) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
    qneg_q <= qneg_d; rneg_q <= rneg_d;
  end
endmodule
`default_nettype wire

### rtl/tagged_rational_alu.sv
// Rational ALU: one beat in, one beat out. The single bit-serial divider is
// shared by integer division, the Euclid loop and the two reducing divisions,
// and sets how long a fraction takes. A finished result waits in an output
// register, so the next beat is taken while it is held; a second result
// then waits until the first is taken.
// ----------------------------------------------------------------------------
// tagged_rational_alu
// Sequencer around one multiplier and one shared divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tagged_rational_alu_defines.svh"
module tagged_rational_alu import tra_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // action[2:0] num_a[34:3] den_a[66:35] num_b[98:67] den_b[130:99],
  // zero fill to 136
  input  wire logic [135:0] s_axis_tdata,
  // kind_a[1:0] kind_b[3:2]
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_num[31:0] result_den[63:32] compare_true[64] error[66:65],
  // zero fill to 72
  output logic [71:0]       m_axis_tdata,
  // result_kind[0]
  output logic              m_axis_tuser
);
  localparam int unsigned W = WordBits;
  typedef enum logic [11:0] {
    StIdle = 12'b000000000001, StMul1 = 12'b000000000010, StMul2 = 12'b000000000100,
    StMul3 = 12'b000000001000, StEval = 12'b000000010000, StIdiv = 12'b000000100000,
    StGcd  = 12'b000001000000, StRedN = 12'b000010000000, StRedD = 12'b000100000000,
    StFix  = 12'b001000000000, StOut  = 12'b010000000000, StWait = 12'b100000000000
  } state_e;
  state_e st_q, st_d, ret_q, ret_d;

  logic [2:0] act_q, act_d;
  logic frac_q, frac_d;
  logic [W-1:0] na_q, da_q, nb_q, db_q, na_d, da_d, nb_d, db_d;
  logic [W-1:0] p1_q, p1_d, p2_q, p2_d, fn_q, fn_d, fd_q, fd_d;
  logic [W-1:0] ga_q, ga_d, gb_q, gb_d;
  logic [W-1:0] rn_q, rn_d, rd_q, rd_d;
  logic rk_q, rk_d, cmp_q, cmp_d;
  logic [1:0] err_q, err_d;
  logic ovalid_q, ovalid_d, okind_q, okind_d;
  logic [71:0] obeat_q, obeat_d;
  logic [W-1:0] mul_a, mul_b, mul_p;
  logic div_start;
  logic [W-1:0] div_a, div_b, div_q, div_r;
  logic div_done;

  function automatic logic [W-1:0] sx(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[W-1:0];
  endfunction

  function automatic logic [31:0] lo32(input logic [W-1:0] v);
    logic [W+31:0] e;
    e = {{32{v[W-1]}}, v};
    return e[31:0];
  endfunction

  assign mul_p = W'(mul_a * mul_b);

  tra_divider #(.WordBits(W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(div_a), .b_i(div_b),
    .done_o(div_done), .q_o(div_q), .r_o(div_r)
  );

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obeat_q;
  assign m_axis_tuser  = okind_q;

  always_comb begin
    logic [1:0] ka, kb;
    logic [W-1:0] lhs, rhs;
    st_d = st_q; ret_d = ret_q; act_d = act_q; frac_d = frac_q;
    na_d = na_q; da_d = da_q; nb_d = nb_q; db_d = db_q;
    p1_d = p1_q; p2_d = p2_q; fn_d = fn_q; fd_d = fd_q;
    ga_d = ga_q; gb_d = gb_q; rn_d = rn_q; rd_d = rd_q;
    rk_d = rk_q; cmp_d = cmp_q; err_d = err_q;
    ovalid_d = ovalid_q; okind_d = okind_q; obeat_d = obeat_q;
    mul_a = na_q; mul_b = db_q;
    div_start = 1'b0; div_a = ga_q; div_b = gb_q;
    ka = s_axis_tuser[1:0]; kb = s_axis_tuser[3:2];
    lhs = frac_q ? p1_q : na_q;
    rhs = frac_q ? p2_q : nb_q;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: if (s_axis_tvalid) begin
        act_d = s_axis_tdata[2:0];
        na_d = sx(s_axis_tdata[34:3]); nb_d = sx(s_axis_tdata[98:67]);
        da_d = (ka == KindInt) ? W'(1) : sx(s_axis_tdata[66:35]);
        db_d = (kb == KindInt) ? W'(1) : sx(s_axis_tdata[130:99]);
        frac_d = (ka == KindFrac) || (kb == KindFrac);
        rk_d = 1'b0; rn_d = '0; rd_d = W'(1); cmp_d = 1'b0; err_d = ErrNone;
        if (ka[1] || kb[1]) begin
          err_d = ErrReal; st_d = StOut;
        end else if (s_axis_tdata[2:0] == ActUnused) st_d = StOut;
        else st_d = StMul1;
      end
      StMul1: begin
        mul_a = na_q; mul_b = (act_q == ActMul) ? nb_q : db_q; p1_d = mul_p;
        st_d = StMul2;
      end
      StMul2: begin
        mul_a = (act_q == ActMul || act_q == ActDiv) ? da_q : nb_q;
        mul_b = (act_q == ActMul) ? db_q : (act_q == ActDiv) ? nb_q : da_q;
        p2_d = mul_p;
        st_d = StMul3;
      end
      StMul3: begin
        mul_a = da_q; mul_b = (act_q == ActDiv) ? nb_q : db_q; fd_d = mul_p;
        st_d = StEval;
      end
      StEval: begin
        priority if (act_q >= ActGt) begin
          if (act_q == ActGt) cmp_d = $signed(rhs) < $signed(lhs);
          else if (act_q == ActLt) cmp_d = $signed(lhs) < $signed(rhs);
          else cmp_d = (lhs == rhs);
          st_d = StOut;
        end else if (!frac_q && act_q != ActDiv) begin
          if (act_q == ActAdd) rn_d = na_q + nb_q;
          else if (act_q == ActSub) rn_d = na_q - nb_q;
          else rn_d = p1_q;
          st_d = StOut;
        end else if (!frac_q) begin
          if (nb_q == '0) begin
            err_d = ErrDivZero; st_d = StOut;
          end else begin
            fn_d = na_q; fd_d = nb_q; div_a = na_q; div_b = nb_q;
            div_start = 1'b1; st_d = StWait; ret_d = StIdiv;
          end
        end else begin
          if (act_q == ActAdd) fn_d = p1_q + p2_q;
          else if (act_q == ActSub) fn_d = p1_q - p2_q;
          else fn_d = p1_q;
          if (fd_q == '0) begin
            err_d = ErrDivZero; st_d = StOut;
          end else begin
            ga_d = fn_d; gb_d = fd_q; st_d = StGcd;
          end
        end
      end
      StIdiv: begin
        if (div_r == '0) begin
          rn_d = div_q; st_d = StOut;
        end else begin
          ga_d = fn_q; gb_d = fd_q; st_d = StGcd;
        end
      end
      StGcd: begin
        if (gb_q == '0) begin
          div_a = fn_q; div_b = ga_q; div_start = 1'b1;
          st_d = StWait; ret_d = StRedN;
        end else begin
          div_a = ga_q; div_b = gb_q; div_start = 1'b1;
          st_d = StWait; ret_d = StGcd;
        end
      end
      StWait: if (div_done) begin
        st_d = ret_q;
        if (ret_q == StGcd) begin
          ga_d = gb_q; gb_d = div_r;
        end else if (ret_q == StRedN) begin
          rn_d = div_q; div_a = fd_q; div_b = ga_q; div_start = 1'b1;
          st_d = StWait; ret_d = StRedD;
        end else if (ret_q == StRedD) begin
          rd_d = div_q; st_d = StFix;
        end
      end
      StRedN: st_d = StFix;
      StRedD: st_d = StFix;
      StFix: begin
        if (rd_q[W-1]) begin
          rn_d = ~rn_q + 1'b1; rd_d = ~rd_q + 1'b1;
        end
        rk_d = 1'b1; st_d = StOut;
      end
      // hand the result to the output register once it is free
      StOut: if (!ovalid_q || m_axis_tready) begin
        ovalid_d = 1'b1; okind_d = rk_q;
        obeat_d = {5'd0, err_q, cmp_q, lo32(rd_q), lo32(rn_q)};
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ret_q <= StIdle; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; ret_q <= ret_d; ovalid_q <= ovalid_d;
    end
  end
  always_ff @(posedge clk_i) begin
    act_q <= act_d; frac_q <= frac_d; na_q <= na_d; da_q <= da_d;
    nb_q <= nb_d; db_q <= db_d; p1_q <= p1_d; p2_q <= p2_d;
    fn_q <= fn_d; fd_q <= fd_d; ga_q <= ga_d; gb_q <= gb_d;
    rn_q <= rn_d; rd_q <= rd_d; rk_q <= rk_d; cmp_q <= cmp_d; err_q <= err_d;
    okind_q <= okind_d; obeat_q <= obeat_d;
  end

  `TRA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `TRA_ASSERT_IMP(a_err_fixed, m_axis_tvalid && m_axis_tdata[66:65] != ErrNone, m_axis_tdata[31:0] == '0 && !m_axis_tuser)
  `TRA_ASSERT_IMP(a_frac_den, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[64] && m_axis_tdata[66:65] == ErrNone)
endmodule
`default_nettype wire
